// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

  // Field widths of the stream beats
  localparam int unsigned KindW = 2;
  localparam int unsigned CharW = 8;
  localparam int unsigned AddrW = 11;
  localparam int unsigned PosW  = 11;
  localparam int unsigned CellW = 16;
  localparam int unsigned AttrW = 8;

  // Item kinds; the fourth code changes nothing and only yields a result beat
  localparam logic [KindW-1:0] KIND_WRITE = 2'd0;
  localparam logic [KindW-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KindW-1:0] KIND_READ  = 2'd2;

  // Control characters
  localparam logic [CharW-1:0] CH_BS    = 8'h08;
  localparam logic [CharW-1:0] CH_TAB   = 8'h09;
  localparam logic [CharW-1:0] CH_LF    = 8'h0A;
  localparam logic [CharW-1:0] CH_CR    = 8'h0D;
  localparam logic [CharW-1:0] CH_SPACE = 8'h20;

  localparam logic [AttrW-1:0] ATTR_RESET = 8'h07;

  // Register index as seen in paddr[2]
  localparam logic IDX_ATTR = 1'b0;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_TAB,
    ST_SCROLL,
    ST_BLANK,
    ST_CLEAR,
    ST_READ,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [AddrW-1:0] read_address;
    logic [CharW-1:0] char_code;
    logic [KindW-1:0] kind;
  } item_t;

  typedef struct packed {
    logic [CellW-1:0] cell_data;
    logic [PosW-1:0]  cursor_position;
  } result_t;

  function automatic logic [CellW-1:0] make_cell(input logic [AttrW-1:0] attr,
                                                 input logic [CharW-1:0] ch);
    return {attr, ch};
  endfunction

endpackage

// ===== rtl/tcw_ram.sv =====
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tcw_cfg.sv =====
module tcw_cfg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel_i,
  input  logic                     penable_i,
  input  logic                     pwrite_i,
  input  logic                     paddr_i,
  input  logic [31:0]              pwdata_i,
  output logic [31:0]              prdata_o,
  output logic                     pready_o,
  output logic [tcw_pkg::AttrW-1:0] attr_o
);

  logic [tcw_pkg::AttrW-1:0] attr_q, attr_d;
  logic                      wr_en;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i & penable_i & pwrite_i & (paddr_i == tcw_pkg::IDX_ATTR);

  always_comb begin
    attr_d = attr_q;
    if (wr_en) begin
      attr_d = pwdata_i[tcw_pkg::AttrW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tcw_pkg::ATTR_RESET;
    end else begin
      attr_q <= attr_d;
    end
  end

  assign prdata_o = (paddr_i == tcw_pkg::IDX_ATTR) ? 32'(attr_q) : 32'd0;
  assign attr_o   = attr_q;

endmodule

// ===== rtl/tcw_ctrl.sv =====
module tcw_ctrl #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25,
  localparam int unsigned CellCount = COLUMNS * ROWS,
  localparam int unsigned AW = $clog2(CellCount),
  localparam int unsigned PW = $clog2(CellCount + 1),
  localparam int unsigned CW = $clog2(COLUMNS),
  localparam int unsigned TW = $clog2(COLUMNS + 1),
  localparam int unsigned SW = $clog2(COLUMNS + 4),
  localparam int unsigned RW = $clog2(ROWS)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  tcw_pkg::item_t            in_item_i,
  input  logic [tcw_pkg::AttrW-1:0] attr_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output tcw_pkg::result_t          out_res_o,
  output logic                      ram_we_o,
  output logic [AW-1:0]             ram_waddr_o,
  output logic [tcw_pkg::CellW-1:0] ram_wdata_o,
  output logic [AW-1:0]             ram_raddr_o,
  input  logic [tcw_pkg::CellW-1:0] ram_rdata_i
);

  tcw_pkg::state_e           state_q, state_d;
  tcw_pkg::item_t            item_q;
  logic [CW-1:0]             col_q, col_d;
  logic [RW-1:0]             row_q, row_d;
  logic [PW-1:0]             ptr_q, ptr_d;
  logic [CW-1:0]             tab_col_q, tab_col_d;
  logic [TW-1:0]             tab_end_q, tab_end_d;
  logic [tcw_pkg::CellW-1:0] data_q, data_d;
  logic                      out_vld_q, out_vld_d;
  tcw_pkg::result_t          res_q, res_d;

  logic [AW-1:0] row_base;
  logic [AW-1:0] cur_lin;
  logic          last_col;
  logic          last_row;
  logic [SW-1:0] tab_stop;
  logic [TW-1:0] tab_lim;
  logic          tab_last;
  logic          addr_ok;
  logic          ptr_end;
  logic          out_free;

  assign row_base = AW'(32'(row_q) * COLUMNS);
  assign cur_lin  = row_base + AW'(col_q);
  assign last_col = (col_q == CW'(COLUMNS - 1));
  assign last_row = (row_q == RW'(ROWS - 1));
  assign tab_stop = (SW'(col_q) + SW'(4)) & ~SW'(3);
  assign tab_lim  = (32'(tab_stop) >= COLUMNS) ? TW'(COLUMNS) : TW'(tab_stop);
  assign tab_last = ((TW'(tab_col_q) + TW'(1)) == tab_end_q);
  assign addr_ok  = (32'(item_q.read_address) < CellCount);
  assign ptr_end  = (ptr_q == PW'(CellCount - 1));
  assign out_free = !out_vld_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tcw_pkg::ST_INIT: begin
        if (ptr_end) state_d = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = tcw_pkg::ST_EXEC;
      end
      tcw_pkg::ST_EXEC: begin
        case (item_q.kind)
          tcw_pkg::KIND_WRITE: begin
            case (item_q.char_code)
              tcw_pkg::CH_CR:  state_d = tcw_pkg::ST_EMIT;
              tcw_pkg::CH_LF:  state_d = last_row ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_EMIT;
              tcw_pkg::CH_TAB: state_d = tcw_pkg::ST_TAB;
              tcw_pkg::CH_BS:  state_d = tcw_pkg::ST_EMIT;
              default: begin
                state_d = (last_col && last_row) ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_EMIT;
              end
            endcase
          end
          tcw_pkg::KIND_CLEAR: state_d = tcw_pkg::ST_CLEAR;
          tcw_pkg::KIND_READ:  state_d = addr_ok ? tcw_pkg::ST_READ : tcw_pkg::ST_EMIT;
          default:             state_d = tcw_pkg::ST_EMIT;
        endcase
      end
      tcw_pkg::ST_TAB: begin
        if (tab_last) state_d = tcw_pkg::ST_EMIT;
      end
      tcw_pkg::ST_SCROLL: begin
        if (ptr_q == PW'(CellCount)) state_d = tcw_pkg::ST_BLANK;
      end
      tcw_pkg::ST_BLANK: begin
        if (ptr_end) state_d = tcw_pkg::ST_EMIT;
      end
      tcw_pkg::ST_CLEAR: begin
        if (ptr_end) state_d = tcw_pkg::ST_EMIT;
      end
      tcw_pkg::ST_READ: begin
        state_d = tcw_pkg::ST_EMIT;
      end
      tcw_pkg::ST_EMIT: begin
        if (out_free) state_d = tcw_pkg::ST_IDLE;
      end
      default: state_d = tcw_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    in_ready_o  = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = cur_lin;
    ram_wdata_o = tcw_pkg::make_cell(attr_i, tcw_pkg::CH_SPACE);
    ram_raddr_o = AW'(item_q.read_address);
    col_d       = col_q;
    row_d       = row_q;
    ptr_d       = ptr_q;
    tab_col_d   = tab_col_q;
    tab_end_d   = tab_end_q;
    data_d      = data_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    res_d       = res_q;
    case (state_q)
      tcw_pkg::ST_INIT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = AW'(ptr_q);
        ram_wdata_o = tcw_pkg::make_cell(tcw_pkg::ATTR_RESET, tcw_pkg::CH_SPACE);
        ptr_d       = ptr_end ? '0 : ptr_q + PW'(1);
      end
      tcw_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        data_d     = '0;
      end
      tcw_pkg::ST_EXEC: begin
        case (item_q.kind)
          tcw_pkg::KIND_WRITE: begin
            case (item_q.char_code)
              tcw_pkg::CH_CR: begin
                col_d = '0;
              end
              tcw_pkg::CH_LF: begin
                col_d = '0;
                if (last_row) ptr_d = PW'(COLUMNS);
                else          row_d = row_q + RW'(1);
              end
              tcw_pkg::CH_TAB: begin
                tab_col_d = col_q;
                tab_end_d = tab_lim;
              end
              tcw_pkg::CH_BS: begin
                if (col_q != '0) begin
                  col_d       = col_q - CW'(1);
                  ram_we_o    = 1'b1;
                  ram_waddr_o = cur_lin - AW'(1);
                end
              end
              default: begin
                ram_we_o    = 1'b1;
                ram_wdata_o = tcw_pkg::make_cell(attr_i, item_q.char_code);
                if (last_col) begin
                  col_d = '0;
                  if (last_row) ptr_d = PW'(COLUMNS);
                  else          row_d = row_q + RW'(1);
                end else begin
                  col_d = col_q + CW'(1);
                end
              end
            endcase
          end
          tcw_pkg::KIND_CLEAR: ptr_d = '0;
          default: ;
        endcase
      end
      tcw_pkg::ST_TAB: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = row_base + AW'(tab_col_q);
        if (tab_last) begin
          col_d = (tab_end_q == TW'(COLUMNS)) ? CW'(COLUMNS - 1) : CW'(tab_end_q);
        end else begin
          tab_col_d = tab_col_q + CW'(1);
        end
      end
      tcw_pkg::ST_SCROLL: begin
        // read one row ahead, write back what came out last cycle
        ram_raddr_o = (ptr_q == PW'(CellCount)) ? '0 : AW'(ptr_q);
        ram_we_o    = (ptr_q != PW'(COLUMNS));
        ram_waddr_o = AW'(ptr_q - PW'(COLUMNS + 1));
        ram_wdata_o = ram_rdata_i;
        ptr_d       = (ptr_q == PW'(CellCount)) ? PW'(CellCount - COLUMNS) : ptr_q + PW'(1);
      end
      tcw_pkg::ST_BLANK: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = AW'(ptr_q);
        ptr_d       = ptr_end ? '0 : ptr_q + PW'(1);
      end
      tcw_pkg::ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = AW'(ptr_q);
        if (ptr_end) begin
          ptr_d = '0;
          col_d = '0;
          row_d = '0;
        end else begin
          ptr_d = ptr_q + PW'(1);
        end
      end
      tcw_pkg::ST_READ: begin
        data_d = ram_rdata_i;
      end
      tcw_pkg::ST_EMIT: begin
        if (out_free) begin
          out_vld_d             = 1'b1;
          res_d.cursor_position = tcw_pkg::PosW'(cur_lin);
          res_d.cell_data       = data_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tcw_pkg::ST_INIT;
      col_q     <= '0;
      row_q     <= '0;
      ptr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      col_q     <= col_d;
      row_q     <= row_d;
      ptr_q     <= ptr_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
    tab_col_q <= tab_col_d;
    tab_end_q <= tab_end_d;
    data_q    <= data_d;
    res_q     <= res_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = res_q;

endmodule

// ===== rtl/text_console_writer.sv =====
// Text-mode console engine over a ROWS x COLUMNS screen of 16-bit cells
// (character in the low byte, attribute in the high byte), held in one
// single-port-write / registered-read RAM. Each input beat is a character
// write, a screen clear or a cell read, and yields exactly one output beat
// carrying the linear cursor position and, for a read, the cell. After reset
// the block sweeps the RAM once, one cell per cycle, writing blanks with
// attribute 0x07; input is held off until the sweep ends, while APB writes
// are still taken. One item is worked on at a time, and the next is accepted
// while the previous result sits in the output register. A tab blanks the
// cells up to the next tab stop (at most 4); a line feed or wrap off the
// bottom row scrolls, copying each row up by one and blanking the bottom
// row; a clear writes every cell and homes the cursor. A stalled result
// holds the next item once it reaches the output stage. The single RAM
// write port makes tabs, scrolls and clears sweep one cell at a time. The
// attribute register (APB byte address 0) applies to cells written or
// blanked after it changes; write it only while the block is idle.
module text_console_writer #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // kind[1:0], char_code[9:2], read_address[20:10]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // cursor_position[10:0], cell_data[26:11]
  // APB config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CellCount = COLUMNS * ROWS;
  localparam int unsigned AW        = $clog2(CellCount);

  tcw_pkg::item_t            item;
  tcw_pkg::result_t          res;
  logic [tcw_pkg::AttrW-1:0] attr;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [AW-1:0]             ram_raddr;
  logic [tcw_pkg::CellW-1:0] ram_wdata;
  logic [tcw_pkg::CellW-1:0] ram_rdata;

  // unpack the input beat; bits 23:21 are padding
  assign item.kind         = s_axis_tdata[1:0];
  assign item.char_code    = s_axis_tdata[9:2];
  assign item.read_address = s_axis_tdata[20:10];

  assign m_axis_tdata = {5'd0, res.cell_data, res.cursor_position};

  // attribute register; paddr[2] picks the register word
  tcw_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr[2]),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .attr_o    (attr)
  );

  // sequencer: cursor, tab/scroll/clear sweeps, output register
  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (item),
    .attr_i      (attr),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // screen store
  tcw_ram #(
    .WIDTH (tcw_pkg::CellW),
    .DEPTH (CellCount)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== rtl/tcw_chk.sv =====
module tcw_chk #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  localparam int unsigned CellCount = COLUMNS * ROWS;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_q, pend_d;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // items accepted but not yet delivered
  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc)      pend_d = pend_q + 2'd1;
    else if (!in_acc && out_acc) pend_d = pend_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // no result without an item behind it
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 2'd0)
    else $error("result beat without pending item");

  // at most one item in work plus one waiting result
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd2 |-> !s_axis_tready)
    else $error("input taken with work and output both full");

  // cursor stays on screen
  a_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (CellCount > 2047) || (32'(m_axis_tdata[10:0]) < CellCount))
    else $error("cursor position off screen");

endmodule

bind text_console_writer tcw_chk #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_chk (.*);
